[rtl/gbnr_pkg.sv]
package gbnr_pkg;

  // store sizes
  localparam int MAX_RECTS   = 4096;
  localparam int MAX_CELLS   = 4096;
  localparam int MAX_ENTRIES = 16384;

  // operation codes
  localparam logic [2:0] OP_X_BOUNDS    = 3'd0;
  localparam logic [2:0] OP_Z_BOUNDS    = 3'd1;
  localparam logic [2:0] OP_NEAR_HEIGHT = 3'd2;
  localparam logic [2:0] OP_FAR_HEIGHT  = 3'd3;
  localparam logic [2:0] OP_CELL_START  = 3'd4;
  localparam logic [2:0] OP_CELL_ENTRY  = 3'd5;
  localparam logic [2:0] OP_LOCATE      = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Z     = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE    = 3'd2;
  localparam logic [2:0] REG_GRID_COLUMNS = 3'd3;
  localparam logic [2:0] REG_GRID_ROWS    = 3'd4;
  localparam logic [2:0] REG_REACH        = 3'd5;
  localparam logic [2:0] REG_HEIGHT_TOL   = 3'd6;

  // shared divider: 49-bit dividend, 33-bit divisor, one bit per cycle
  localparam int DIV_NW = 49;
  localparam int DIV_DW = 33;
  localparam int DIV_CW = 6;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DF_START, ST_DF_WAIT, ST_RANGE, ST_CS_RD0, ST_CS_RD1, ST_CS_END,
    ST_ENT_CHK, ST_ENT_WAIT, ST_GAP, ST_CHK_GAP, ST_SQX, ST_SQZ, ST_SUM, ST_CHK_S,
    ST_FU_START, ST_FU_WAIT, ST_FV_START, ST_FV_WAIT, ST_SINIT, ST_SW, ST_SM, ST_SA,
    ST_HGT, ST_VD, ST_CHK_V, ST_VSQ, ST_SCORE, ST_UPD, ST_NEXT_E, ST_NEXT_C,
    ST_SQ_START, ST_SQ_WAIT, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_DF_START, CMD_DF_WAIT, CMD_RANGE, CMD_CS_NEXT, CMD_CS_END,
    CMD_GAP, CMD_SQX, CMD_SQZ, CMD_SUM, CMD_FU_START, CMD_FU_WAIT, CMD_FV_START,
    CMD_FV_WAIT, CMD_SINIT, CMD_SW, CMD_SM, CMD_SA, CMD_HGT, CMD_VD, CMD_VSQ,
    CMD_SCORE, CMD_UPD, CMD_NEXT_E, CMD_NEXT_C, CMD_SQ_START, CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic locate_fire;
    logic div_done;
    logic sqrt_done;
    logic dsel_last;
    logic outside;
    logic ent_more;
    logic gap_far;
    logic s_far;
    logic frac_spec;
    logic k_last;
    logic v_far;
    logic last_cell;
    logic out_free;
  } status_t;

endpackage

[rtl/gbnr_div.sv]
module gbnr_div
  import gbnr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo,
  output logic [DIV_DW-1:0] rem
);

  logic [DIV_DW:0]   part;
  logic [DIV_DW-1:0] divisor;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {part[DIV_DW-1:0], quo[DIV_NW-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign rem   = part[DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num;
      part    <= '0;
      divisor <= den;
    end else if (busy) begin
      part <= fits ? (trial - {1'b0, divisor}) : trial;
      quo  <= {quo[DIV_NW-2:0], fits};
    end
  end

endmodule

[rtl/gbnr_sqrt.sv]
module gbnr_sqrt
  import gbnr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [30:0] root
);

  logic [63:0] rest;
  logic [63:0] acc;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = acc + bitv;
  assign root  = acc[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rest <= value;
      acc  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (rest >= trial) begin
        rest <= rest - trial;
        acc  <= (acc >> 1) + bitv;
      end else begin
        acc <= acc >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

[rtl/gbnr_datapath.sv]
module gbnr_datapath
  import gbnr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [2:0]         operation,
  input  logic [13:0]        index,
  input  logic signed [31:0] word_a,
  input  logic signed [31:0] word_b,
  input  logic signed [31:0] word_c,
  input  logic               write_enable,
  input  logic [2:0]         register_index,
  input  logic [31:0]        write_data,
  input  cmd_t               cmd,
  output status_t            stat,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               found,
  output logic [11:0]        polygon,
  output logic signed [31:0] surface_height,
  output logic [30:0]        planar_distance,
  output logic [30:0]        vertical_distance
);

  // configuration
  logic signed [31:0] origin_x, origin_z;
  logic [30:0] cell_size, reach, height_tol;
  logic [6:0]  grid_columns, grid_rows;
  logic [6:0]  cols, rows;
  logic [30:0] cellv;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_z     <= '0;
      cell_size    <= 31'd256;
      grid_columns <= 7'd1;
      grid_rows    <= 7'd1;
      reach        <= '0;
      height_tol   <= '0;
    end else if (write_enable) begin
      case (register_index)
        REG_ORIGIN_X:     origin_x <= write_data;
        REG_ORIGIN_Z:     origin_z <= write_data;
        REG_CELL_SIZE:    cell_size <= write_data[30:0];
        REG_GRID_COLUMNS: grid_columns <= write_data[6:0];
        REG_GRID_ROWS:    grid_rows <= write_data[6:0];
        REG_REACH:        reach <= write_data[30:0];
        REG_HEIGHT_TOL:   height_tol <= write_data[30:0];
        default: ;
      endcase
    end
  end

  assign cols  = (grid_columns == 7'd0) ? 7'd1 : ((grid_columns > 7'd64) ? 7'd64 : grid_columns);
  assign rows  = (grid_rows == 7'd0) ? 7'd1 : ((grid_rows > 7'd64) ? 7'd64 : grid_rows);
  assign cellv = (cell_size == 31'd0) ? 31'd1 : cell_size;

  // stores
  logic [63:0] rect_x [MAX_RECTS];
  logic [63:0] rect_z [MAX_RECTS];
  logic [63:0] rect_n [MAX_RECTS];
  logic [63:0] rect_f [MAX_RECTS];
  logic [14:0] cell_starts [MAX_CELLS+1];
  logic [11:0] cell_entries [MAX_ENTRIES];

  logic [63:0] rx_rd, rz_rd, rn_rd, rf_rd;
  logic [14:0] cs_rd;
  logic [11:0] ent_rd;
  logic [12:0] cs_addr;
  logic [11:0] cidx;
  logic [14:0] e, cend;
  logic [5:0]  row, col;
  logic        rect_wr;

  assign rect_wr = in_fire && (index < 14'(MAX_RECTS));

  always_ff @(posedge clk) begin
    if (rect_wr && operation == OP_X_BOUNDS) rect_x[index[11:0]] <= {word_b, word_a};
    if (rect_wr && operation == OP_Z_BOUNDS) rect_z[index[11:0]] <= {word_b, word_a};
    if (rect_wr && operation == OP_NEAR_HEIGHT) rect_n[index[11:0]] <= {word_b, word_a};
    if (rect_wr && operation == OP_FAR_HEIGHT) rect_f[index[11:0]] <= {word_b, word_a};
    rx_rd <= rect_x[ent_rd];
    rz_rd <= rect_z[ent_rd];
    rn_rd <= rect_n[ent_rd];
    rf_rd <= rect_f[ent_rd];
  end

  always_ff @(posedge clk) begin
    if (in_fire && operation == OP_CELL_START && index <= 14'(MAX_CELLS))
      cell_starts[index[12:0]] <= word_a[14:0];
    cs_rd <= cell_starts[cs_addr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && operation == OP_CELL_ENTRY)
      cell_entries[index] <= word_a[11:0];
    ent_rd <= cell_entries[e[13:0]];
  end

  assign cidx    = 12'(row * cols + 13'(col));
  assign cs_addr = (cmd == CMD_CS_NEXT) ? ({1'b0, cidx} + 13'd1) : {1'b0, cidx};

  // query and grid range
  logic signed [31:0] qx, qy, qz;
  logic [61:0] rch2;
  logic [1:0]  dsel;
  logic signed [36:0] lc, hc, lr, hr;
  logic signed [34:0] fnum, rch_s;
  logic        fneg;
  logic [34:0] fmag;
  logic signed [36:0] qmag, fq, cols_s, rows_s;
  logic [5:0]  c0, c1, r0, r1;
  logic        locate_fire;

  assign locate_fire = in_fire && operation == OP_LOCATE;
  assign rch_s = $signed({4'b0, reach});

  always_comb begin
    case (dsel)
      2'd0:    fnum = 35'(qx) - rch_s - 35'(origin_x);
      2'd1:    fnum = 35'(qx) + rch_s - 35'(origin_x);
      2'd2:    fnum = 35'(qz) - rch_s - 35'(origin_z);
      default: fnum = 35'(qz) + rch_s - 35'(origin_z);
    endcase
  end

  assign fneg = fnum[34];
  assign fmag = fneg ? 35'(-fnum) : 35'(fnum);

  // divider sharing
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den, div_rem;
  logic signed [31:0] xlo, xhi, zlo, zhi;
  logic signed [32:0] span_u, span_v, pu, pv;
  logic        u_spec, v_spec;
  logic [16:0] u_sv, v_sv, u, v, nu, nv;

  assign xlo = rx_rd[31:0];
  assign xhi = rx_rd[63:32];
  assign zlo = rz_rd[31:0];
  assign zhi = rz_rd[63:32];
  assign span_u = 33'(xhi) - 33'(xlo);
  assign span_v = 33'(zhi) - 33'(zlo);
  assign pu = 33'(qx) - 33'(xlo);
  assign pv = 33'(qz) - 33'(zlo);
  assign u_spec = span_u <= 0 || pu <= 0 || qx >= xhi;
  assign v_spec = span_v <= 0 || pv <= 0 || qz >= zhi;
  assign u_sv = (span_u <= 0 || pu <= 0) ? 17'd0 : 17'h10000;
  assign v_sv = (span_v <= 0 || pv <= 0) ? 17'd0 : 17'h10000;

  always_comb begin
    case (cmd)
      CMD_FU_START: begin
        div_num = {pu, 16'b0};
        div_den = span_u;
      end
      CMD_FV_START: begin
        div_num = {pv, 16'b0};
        div_den = span_v;
      end
      default: begin
        div_num = {14'b0, fmag};
        div_den = {2'b0, cellv};
      end
    endcase
  end

  assign div_start = (cmd == CMD_DF_START) || (cmd == CMD_FU_START && !u_spec) ||
                     (cmd == CMD_FV_START && !v_spec);

  gbnr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign qmag = $signed({2'b0, div_quo[34:0]});
  assign fq   = fneg ? (-qmag - 37'(div_rem != '0)) : qmag;

  assign cols_s = $signed({30'b0, cols});
  assign rows_s = $signed({30'b0, rows});
  assign c0 = (lc < 0) ? 6'd0 : lc[5:0];
  assign r0 = (lr < 0) ? 6'd0 : lr[5:0];
  assign c1 = (hc >= cols_s) ? 6'(cols - 7'd1) : hc[5:0];
  assign r1 = (hr >= rows_s) ? 6'(rows - 7'd1) : hr[5:0];

  // per-rectangle arithmetic
  logic signed [32:0] dxl, dxh, dzl, dzh;
  logic [31:0] dx, dz;
  logic [61:0] dxsq, dzsq, vdsq;
  logic [62:0] s;
  logic [1:0]  k;
  logic [33:0] wmux, w;
  logic signed [31:0] hmux, h;
  logic signed [66:0] prod, acc, hsum;
  logic signed [32:0] vdiff;
  logic [32:0] vd;
  logic [63:0] score;

  assign dxl = 33'(xlo) - 33'(qx);
  assign dxh = 33'(qx) - 33'(xhi);
  assign dzl = 33'(zlo) - 33'(qz);
  assign dzh = 33'(qz) - 33'(zhi);
  assign nu = 17'h10000 - u;
  assign nv = 17'h10000 - v;

  always_comb begin
    case (k)
      2'd0: begin
        wmux = nu * nv;
        hmux = rn_rd[31:0];
      end
      2'd1: begin
        wmux = nu * v;
        hmux = rn_rd[63:32];
      end
      2'd2: begin
        wmux = u * v;
        hmux = rf_rd[31:0];
      end
      default: begin
        wmux = u * nv;
        hmux = rf_rd[63:32];
      end
    endcase
  end

  assign hsum  = acc + 67'sd2147483648;
  assign vdiff = 33'(qy) - 33'(h);

  // best candidate
  logic [63:0] best_score;
  logic [61:0] best_s;
  logic [11:0] best_poly;
  logic signed [31:0] best_h;
  logic [30:0] best_vd;
  logic        best_found;
  logic        sqrt_done;
  logic [30:0] sqrt_root;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dsel       <= '0;
      best_found <= 1'b0;
    end else if (locate_fire) begin
      qx         <= word_a;
      qy         <= word_b;
      qz         <= word_c;
      rch2       <= reach * reach;
      dsel       <= '0;
      best_found <= 1'b0;
      best_score <= '0;
      best_s     <= '0;
      best_poly  <= '0;
      best_h     <= '0;
      best_vd    <= '0;
    end else begin
      case (cmd)
        CMD_DF_WAIT: begin
          if (div_done) begin
            case (dsel)
              2'd0:    lc <= fq;
              2'd1:    hc <= fq;
              2'd2:    lr <= fq;
              default: hr <= fq;
            endcase
            dsel <= dsel + 2'd1;
          end
        end
        CMD_RANGE: begin
          row <= r0;
          col <= c0;
        end
        CMD_CS_NEXT: e <= cs_rd;
        CMD_CS_END:  cend <= cs_rd;
        CMD_GAP: begin
          dx <= (dxl > 0 || dxh > 0) ? ((dxl > dxh) ? dxl[31:0] : dxh[31:0]) : 32'd0;
          dz <= (dzl > 0 || dzh > 0) ? ((dzl > dzh) ? dzl[31:0] : dzh[31:0]) : 32'd0;
        end
        CMD_SQX: dxsq <= dx[30:0] * dx[30:0];
        CMD_SQZ: dzsq <= dz[30:0] * dz[30:0];
        CMD_SUM: s <= {1'b0, dxsq} + {1'b0, dzsq};
        CMD_FU_START: if (u_spec) u <= u_sv;
        CMD_FU_WAIT:  if (div_done) u <= div_quo[16:0];
        CMD_FV_START: if (v_spec) v <= v_sv;
        CMD_FV_WAIT:  if (div_done) v <= div_quo[16:0];
        CMD_SINIT: begin
          acc <= '0;
          k   <= '0;
        end
        CMD_SW: w <= wmux;
        CMD_SM: prod <= $signed({1'b0, w}) * hmux;
        CMD_SA: begin
          acc <= acc + prod;
          k   <= k + 2'd1;
        end
        CMD_HGT:   h <= hsum[63:32];
        CMD_VD:    vd <= vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
        CMD_VSQ:   vdsq <= vd[30:0] * vd[30:0];
        CMD_SCORE: score <= {1'b0, s} + {2'b0, vdsq};
        CMD_UPD: begin
          if (!best_found || score < best_score) begin
            best_found <= 1'b1;
            best_score <= score;
            best_s     <= s[61:0];
            best_poly  <= ent_rd;
            best_h     <= h;
            best_vd    <= vd[30:0];
          end
        end
        CMD_NEXT_E: e <= e + 15'd1;
        CMD_NEXT_C: begin
          if (col == c1) begin
            col <= c0;
            row <= row + 6'd1;
          end else begin
            col <= col + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  gbnr_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd == CMD_SQ_START),
    .value ({2'b0, best_s}),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT && out_free) begin
      found             <= best_found;
      polygon           <= best_poly;
      surface_height    <= best_h;
      planar_distance   <= sqrt_root;
      vertical_distance <= best_vd;
    end
  end

  always_comb begin
    stat.locate_fire = locate_fire;
    stat.div_done    = div_done;
    stat.sqrt_done   = sqrt_done;
    stat.dsel_last   = dsel == 2'd3;
    stat.outside     = hc < 0 || hr < 0 || lc >= cols_s || lr >= rows_s;
    stat.ent_more    = (e < cend) && (e < 15'(MAX_ENTRIES));
    stat.gap_far     = dx > {1'b0, reach} || dz > {1'b0, reach};
    stat.s_far       = s > {1'b0, rch2};
    stat.frac_spec   = (cmd == CMD_FV_START) ? v_spec : u_spec;
    stat.k_last      = k == 2'd3;
    stat.v_far       = vd > {2'b0, height_tol};
    stat.last_cell   = col == c1 && row == r1;
    stat.out_free    = out_free;
  end

endmodule

[rtl/gbnr_ctrl.sv]
module gbnr_ctrl
  import gbnr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t stat,
  output cmd_t    cmd,
  output logic    in_stall
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (stat.locate_fire) state_next = ST_DF_START;
      ST_DF_START: state_next = ST_DF_WAIT;
      ST_DF_WAIT:  if (stat.div_done) state_next = stat.dsel_last ? ST_RANGE : ST_DF_START;
      ST_RANGE:    state_next = stat.outside ? ST_SQ_START : ST_CS_RD0;
      ST_CS_RD0:   state_next = ST_CS_RD1;
      ST_CS_RD1:   state_next = ST_CS_END;
      ST_CS_END:   state_next = ST_ENT_CHK;
      ST_ENT_CHK:  state_next = stat.ent_more ? ST_ENT_WAIT : ST_NEXT_C;
      ST_ENT_WAIT: state_next = ST_GAP;
      ST_GAP:      state_next = ST_CHK_GAP;
      ST_CHK_GAP:  state_next = stat.gap_far ? ST_NEXT_E : ST_SQX;
      ST_SQX:      state_next = ST_SQZ;
      ST_SQZ:      state_next = ST_SUM;
      ST_SUM:      state_next = ST_CHK_S;
      ST_CHK_S:    state_next = stat.s_far ? ST_NEXT_E : ST_FU_START;
      ST_FU_START: state_next = stat.frac_spec ? ST_FV_START : ST_FU_WAIT;
      ST_FU_WAIT:  if (stat.div_done) state_next = ST_FV_START;
      ST_FV_START: state_next = stat.frac_spec ? ST_SINIT : ST_FV_WAIT;
      ST_FV_WAIT:  if (stat.div_done) state_next = ST_SINIT;
      ST_SINIT:    state_next = ST_SW;
      ST_SW:       state_next = ST_SM;
      ST_SM:       state_next = ST_SA;
      ST_SA:       state_next = stat.k_last ? ST_HGT : ST_SW;
      ST_HGT:      state_next = ST_VD;
      ST_VD:       state_next = ST_CHK_V;
      ST_CHK_V:    state_next = stat.v_far ? ST_NEXT_E : ST_VSQ;
      ST_VSQ:      state_next = ST_SCORE;
      ST_SCORE:    state_next = ST_UPD;
      ST_UPD:      state_next = ST_NEXT_E;
      ST_NEXT_E:   state_next = ST_ENT_CHK;
      ST_NEXT_C:   state_next = stat.last_cell ? ST_SQ_START : ST_CS_RD0;
      ST_SQ_START: state_next = ST_SQ_WAIT;
      ST_SQ_WAIT:  if (stat.sqrt_done) state_next = ST_EMIT;
      ST_EMIT:     if (stat.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = state != ST_IDLE;
    case (state)
      ST_DF_START: cmd = CMD_DF_START;
      ST_DF_WAIT:  cmd = CMD_DF_WAIT;
      ST_RANGE:    cmd = CMD_RANGE;
      ST_CS_RD1:   cmd = CMD_CS_NEXT;
      ST_CS_END:   cmd = CMD_CS_END;
      ST_GAP:      cmd = CMD_GAP;
      ST_SQX:      cmd = CMD_SQX;
      ST_SQZ:      cmd = CMD_SQZ;
      ST_SUM:      cmd = CMD_SUM;
      ST_FU_START: cmd = CMD_FU_START;
      ST_FU_WAIT:  cmd = CMD_FU_WAIT;
      ST_FV_START: cmd = CMD_FV_START;
      ST_FV_WAIT:  cmd = CMD_FV_WAIT;
      ST_SINIT:    cmd = CMD_SINIT;
      ST_SW:       cmd = CMD_SW;
      ST_SM:       cmd = CMD_SM;
      ST_SA:       cmd = CMD_SA;
      ST_HGT:      cmd = CMD_HGT;
      ST_VD:       cmd = CMD_VD;
      ST_VSQ:      cmd = CMD_VSQ;
      ST_SCORE:    cmd = CMD_SCORE;
      ST_UPD:      cmd = CMD_UPD;
      ST_NEXT_E:   cmd = CMD_NEXT_E;
      ST_NEXT_C:   cmd = CMD_NEXT_C;
      ST_SQ_START: cmd = CMD_SQ_START;
      ST_EMIT:     cmd = CMD_EMIT;
      default:     cmd = CMD_NONE;
    endcase
  end

endmodule

[rtl/grid_bucket_nearest_rect_locator.sv]
// Nearest rectangle locator over a uniform grid. Store writes (operations 0 to 5) are taken
// back to back while the block is idle. A locate transaction holds the input side stalled
// until its result is in the output register: four grid-range divisions on the shared
// bit-serial divider, then a pass over each cell in range and each entry it lists, where an
// entry is rejected on the bounding gap or on the squared reach test, or else u and v may
// each need the divider; a final square root gives the planar distance. The stores are
// plain memories with no reset: an entry read before it was written returns whatever it
// holds. The output register lets the result wait for the sink while the block goes back
// to idle and accepts store writes.
module grid_bucket_nearest_rect_locator
  import gbnr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic [13:0]        index,
  input  logic signed [31:0] word_a,
  input  logic signed [31:0] word_b,
  input  logic signed [31:0] word_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic [11:0]        polygon,
  output logic signed [31:0] surface_height,
  output logic [30:0]        planar_distance,
  output logic [30:0]        vertical_distance,
  input  logic               write_enable,
  input  logic [2:0]         register_index,
  input  logic [31:0]        write_data
);

  cmd_t    cmd;
  status_t stat;
  logic    in_fire;

  // an input transaction completes only while the controller is idle
  assign in_fire = in_valid && !in_stall;

  gbnr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // stores, configuration, arithmetic and the result register
  gbnr_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .in_fire           (in_fire),
    .operation         (operation),
    .index             (index),
    .word_a            (word_a),
    .word_b            (word_b),
    .word_c            (word_c),
    .write_enable      (write_enable),
    .register_index    (register_index),
    .write_data        (write_data),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .found             (found),
    .polygon           (polygon),
    .surface_height    (surface_height),
    .planar_distance   (planar_distance),
    .vertical_distance (vertical_distance)
  );

  // a locate transaction keeps the block busy on the following cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_LOCATE) |=> in_stall)
    else $error("locate transaction did not occupy the block");

  // an empty search gives all-zero fields
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (polygon == 12'd0 && surface_height == 32'sd0 &&
                               planar_distance == 31'd0 && vertical_distance == 31'd0))
    else $error("non-zero fields on an empty result");

  // a new result only appears at the end of a search
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a search in progress");

endmodule
